[rtl/lef_pkg.sv]
// shared types, constants and helpers for the laplacian edge filter
`default_nettype none

package lef_pkg;

  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned OUT_BITS     = SAMPLE_BITS + 3;
  localparam int unsigned MAX_COLS     = 1024;
  localparam int unsigned COL_BITS     = $clog2(MAX_COLS);
  localparam int unsigned CFG_COL_BITS = COL_BITS + 1;
  localparam int unsigned ROW_BITS     = 16;
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  // output queue, depth must be a power of two
  localparam int unsigned OUT_DEPTH    = 8;
  localparam int unsigned OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  typedef enum logic {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } reg_idx_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OUT_BITS-1:0]    wide_t;

  // one line store word: row r-2 and row r-1 samples of a column
  typedef struct packed {
    sample_t older;
    sample_t newer;
  } line_t;

  localparam int unsigned LINE_BITS = $bits(line_t);

  typedef struct packed {
    wide_t pix;
    logic  last;
    logic  eof;
  } res_t;

  // results handed from the stencil stage to the output queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic wide_t ext_sample(input sample_t s);
    return OUT_BITS'(s);
  endfunction

endpackage

`default_nettype wire

[rtl/laplacian_edge_filter.sv]
// top level: 3x3 four-neighbour laplacian over a raster stream of signed samples
//
// Samples enter on the pixel_in channel (in_valid_i / in_stall_o), one per
// transfer, row by row. Frame size comes from the frame_rows and frame_cols
// registers on the APB port; write them only while the block is idle.
// The result for row i, column j leaves once sample (i+1, j) is taken, so
// the first row yields nothing; on the last row each sample first releases
// the result above it and then passes itself through. Border samples are
// copied, interior ones become 4*center minus the four direct neighbours.
// A result is worked out from the stencil stage registers and the line store
// read, then written into the result queue before it shows on out_valid_o.
// Throughput: one sample per cycle while in_stall_o is low, set by the line
// store word written and the two words read per sample; on the last row two
// results per sample leave through the one output port, so in_stall_o holds that row back.
// An eight-entry result queue sits before the output; when the receiver
// stalls it fills and in_stall_o rises, nothing is dropped.
// Reset clears the counters and sets both size registers to one; the line
// store holds no reset value and needs no clearing pass.
`default_nettype none

module laplacian_edge_filter (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // configuration
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [lef_pkg::APB_ADDR_BITS-1:0]      paddr,
  input  wire logic [lef_pkg::APB_DATA_BITS-1:0]      pwdata,
  output logic      [lef_pkg::APB_DATA_BITS-1:0]      prdata,
  output logic                                        pready,
  // sample input
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [lef_pkg::SAMPLE_BITS-1:0] pixel_in_i,
  // result output
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [lef_pkg::OUT_BITS-1:0]         pixel_out_o,
  output logic                                        last_of_run_o,
  output logic                                        end_of_frame_o
);

  typedef struct packed {
    lef_pkg::sample_t              x;
    logic [lef_pkg::COL_BITS-1:0]  j;
    logic                          has_above;
    logic                          last_row;
    logic                          last_col;
    logic                          border;
    logic                          fwd_a;
    logic                          fwd_b;
  } s1_t;

  // configuration registers
  logic [lef_pkg::ROW_BITS-1:0]     frame_rows_q;
  logic [lef_pkg::CFG_COL_BITS-1:0] frame_cols_q;
  logic                             cfg_we;
  lef_pkg::reg_idx_e                reg_idx;

  // position counters
  logic [lef_pkg::ROW_BITS-1:0]     row_q, row_d;
  logic [lef_pkg::COL_BITS-1:0]     col_q, col_d;

  logic [lef_pkg::ROW_BITS-1:0]     rows_eff;
  logic [lef_pkg::CFG_COL_BITS-1:0] cols_eff;
  logic                             last_col, last_row;
  logic                             accept;

  // stencil stage
  logic                             s1_valid_q;
  s1_t                              s1_q, s1_d;
  lef_pkg::line_t                   fwd_a_q;
  lef_pkg::sample_t                 fwd_b_q;
  lef_pkg::sample_t                 left_q;

  logic [lef_pkg::LINE_BITS-1:0]    ram_rdata_a, ram_rdata_b;
  lef_pkg::line_t                   rd_a, rd_b, line_a, wline;
  lef_pkg::sample_t                 center, up, right;
  lef_pkg::wide_t                   lap;
  lef_pkg::res_t                    res_above, res_self;
  lef_pkg::push_t                   push;
  logic [lef_pkg::COL_BITS-1:0]     raddr_b;

  logic [lef_pkg::OUT_CNT_BITS-1:0] q_count;
  logic [lef_pkg::OUT_CNT_BITS:0]   q_need;
  lef_pkg::res_t                    head;

  // ---------------------------------------------------------------- config
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = lef_pkg::reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      lef_pkg::REG_FRAME_ROWS: prdata = lef_pkg::APB_DATA_BITS'(frame_rows_q);
      lef_pkg::REG_FRAME_COLS: prdata = lef_pkg::APB_DATA_BITS'(frame_cols_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q <= lef_pkg::ROW_BITS'(1);
      frame_cols_q <= lef_pkg::CFG_COL_BITS'(1);
    end else if (cfg_we) begin
      unique case (reg_idx)
        lef_pkg::REG_FRAME_ROWS: frame_rows_q <= pwdata[lef_pkg::ROW_BITS-1:0];
        lef_pkg::REG_FRAME_COLS: frame_cols_q <= pwdata[lef_pkg::CFG_COL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- position
  always_comb begin
    rows_eff = (frame_rows_q == '0) ? lef_pkg::ROW_BITS'(1) : frame_rows_q;
    if (frame_cols_q == '0) begin
      cols_eff = lef_pkg::CFG_COL_BITS'(1);
    end else if (frame_cols_q > lef_pkg::CFG_COL_BITS'(lef_pkg::MAX_COLS)) begin
      cols_eff = lef_pkg::CFG_COL_BITS'(lef_pkg::MAX_COLS);
    end else begin
      cols_eff = frame_cols_q;
    end
    last_col = ({1'b0, col_q} + lef_pkg::CFG_COL_BITS'(1)) >= cols_eff;
    last_row = ({1'b0, row_q} + (lef_pkg::ROW_BITS + 1)'(1)) >= {1'b0, rows_eff};
  end

  // room for two more results on top of what the stencil stage may still push
  assign q_need     = {1'b0, q_count} + (s1_valid_q ? (lef_pkg::OUT_CNT_BITS + 1)'(2) : '0)
                      + (lef_pkg::OUT_CNT_BITS + 1)'(2);
  assign in_stall_o = q_need > (lef_pkg::OUT_CNT_BITS + 1)'(lef_pkg::OUT_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + lef_pkg::ROW_BITS'(1);
      end else begin
        col_d = col_q + lef_pkg::COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------------------------------------------------------- line store
  assign raddr_b = col_q + lef_pkg::COL_BITS'(1);

  lef_ram #(
    .Width (lef_pkg::LINE_BITS),
    .Depth (lef_pkg::MAX_COLS)
  ) u_line_ram (
    .clk_i     (clk_i),
    .we_i      (s1_valid_q),
    .waddr_i   (s1_q.j),
    .wdata_i   (wline),
    .raddr_a_i (col_q),
    .raddr_b_i (raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  assign rd_a = lef_pkg::line_t'(ram_rdata_a);
  assign rd_b = lef_pkg::line_t'(ram_rdata_b);

  // a read in the same cycle as the write to that column takes the new word
  always_comb begin
    s1_d.x         = pixel_in_i;
    s1_d.j         = col_q;
    s1_d.has_above = (row_q != '0);
    s1_d.last_row  = last_row;
    s1_d.last_col  = last_col;
    s1_d.border    = (row_q == lef_pkg::ROW_BITS'(1)) || last_col || (col_q == '0);
    s1_d.fwd_a     = s1_valid_q && (s1_q.j == col_q);
    s1_d.fwd_b     = s1_valid_q && (s1_q.j == raddr_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q    <= s1_d;
      fwd_a_q <= wline;
      fwd_b_q <= wline.newer;
    end
    if (s1_valid_q) begin
      left_q <= center;
    end
  end

  // ---------------------------------------------------------------- stencil
  always_comb begin
    line_a      = s1_q.fwd_a ? fwd_a_q : rd_a;
    center      = line_a.newer;
    up          = line_a.older;
    right       = s1_q.fwd_b ? fwd_b_q : rd_b.newer;
    wline.older = center;
    wline.newer = s1_q.x;

    lap = (lef_pkg::ext_sample(center) <<< 2) - lef_pkg::ext_sample(up)
          - lef_pkg::ext_sample(s1_q.x) - lef_pkg::ext_sample(left_q)
          - lef_pkg::ext_sample(right);

    res_above.pix  = s1_q.border ? lef_pkg::ext_sample(center) : lap;
    res_above.last = !s1_q.last_row;
    res_above.eof  = 1'b0;

    res_self.pix   = lef_pkg::ext_sample(s1_q.x);
    res_self.last  = 1'b1;
    res_self.eof   = s1_q.last_col;

    push.cnt    = s1_valid_q ? (2'(s1_q.has_above) + 2'(s1_q.last_row)) : 2'd0;
    push.first  = s1_q.has_above ? res_above : res_self;
    push.second = res_self;
  end

  // ---------------------------------------------------------------- output
  lef_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .count_o     (q_count),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign pixel_out_o    = head.pix;
  assign last_of_run_o  = head.last;
  assign end_of_frame_o = head.eof;

endmodule

`default_nettype wire

[rtl/lef_ram.sv]
// generic ram: one write port, two registered read ports, read returns old data
`default_nettype none

module lef_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

[rtl/lef_out_fifo.sv]
// result queue: takes up to two results a cycle, hands out one per transfer
`default_nettype none

module lef_out_fifo (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lef_pkg::push_t                 push_i,
  output logic [lef_pkg::OUT_CNT_BITS-1:0]    count_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output lef_pkg::res_t                       head_o
);

  lef_pkg::res_t                        entries_q [lef_pkg::OUT_DEPTH];
  logic [lef_pkg::OUT_PTR_BITS-1:0]     wr_ptr_q, wr_ptr_d;
  logic [lef_pkg::OUT_PTR_BITS-1:0]     rd_ptr_q, rd_ptr_d;
  logic [lef_pkg::OUT_CNT_BITS-1:0]     count_q, count_d;
  logic [lef_pkg::OUT_PTR_BITS-1:0]     wr_ptr_next;
  logic                                 pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = entries_q[rd_ptr_q];
  assign count_o     = count_q;
  assign wr_ptr_next = wr_ptr_q + lef_pkg::OUT_PTR_BITS'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + lef_pkg::OUT_PTR_BITS'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + lef_pkg::OUT_PTR_BITS'(pop);
    count_d  = count_q + lef_pkg::OUT_CNT_BITS'(push_i.cnt)
               - lef_pkg::OUT_CNT_BITS'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      entries_q[wr_ptr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

[tb/lef_checker.sv]
`timescale 1ns / 100ps
// checker for the laplacian edge filter: follows every transfer, predicts results and compares

module lef_checker
  import lef_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic                     pready_i,
  input  logic [APB_ADDR_BITS-1:0] paddr_i,
  input  logic [APB_DATA_BITS-1:0] pwdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  sample_t                  pixel_in_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  wide_t                    pixel_out_i,
  input  logic                     last_of_run_i,
  input  logic                     end_of_frame_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  // two most recent rows, indexed by column
  sample_t upper_line [MAX_COLS];
  sample_t mid_line [MAX_COLS];

  logic [ROW_BITS-1:0]     row_pos;
  logic [COL_BITS-1:0]     col_pos;
  logic [ROW_BITS-1:0]     rows_cfg;
  logic [CFG_COL_BITS-1:0] cols_cfg;

  res_t due_results [$];
  res_t oldest;

  assign pending_o = due_results.size();

  task automatic filter_sample(input sample_t x);
    int unsigned n_rows;
    int unsigned n_cols;
    int unsigned j;
    int unsigned r;
    logic        end_col;
    logic        end_row;
    int          acc;
    res_t        res;
    n_rows = (rows_cfg == 0) ? 1 : rows_cfg;
    n_cols = (cols_cfg == 0) ? 1 : cols_cfg;
    if (n_cols > MAX_COLS) n_cols = MAX_COLS;
    j = col_pos;
    r = row_pos;
    end_col = (j + 1 >= n_cols);
    end_row = (r + 1 >= n_rows);
    if (r >= 1) begin
      // the sample below releases the result of the row above
      if (r == 1 || end_col || j == 0) begin
        acc = int'(mid_line[j]);
      end else begin
        // left neighbour was already shifted into upper_line this row
        acc = 4 * int'(mid_line[j]) - int'(upper_line[j]) - int'(x)
              - int'(upper_line[j-1]) - int'(mid_line[j+1]);
      end
      res.pix  = wide_t'(acc);
      res.last = !end_row;
      res.eof  = 1'b0;
      due_results.push_back(res);
    end
    if (end_row) begin
      res.pix  = wide_t'(int'(x));
      res.last = 1'b1;
      res.eof  = end_col;
      due_results.push_back(res);
    end
    upper_line[j] = mid_line[j];
    mid_line[j]   = x;
    if (end_col) begin
      col_pos = '0;
      row_pos = end_row ? '0 : ROW_BITS'(r + 1);
    end else begin
      col_pos = COL_BITS'(j + 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos      = '0;
      col_pos      = '0;
      rows_cfg     = ROW_BITS'(1);
      cols_cfg     = CFG_COL_BITS'(1);
      fail_count_o = 0;
      due_results.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == APB_ADDR_BITS'(4 * REG_FRAME_ROWS))
          rows_cfg = pwdata_i[ROW_BITS-1:0];
        else if (paddr_i == APB_ADDR_BITS'(4 * REG_FRAME_COLS))
          cols_cfg = pwdata_i[CFG_COL_BITS-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $display("%0t unexpected result: pixel_out %0d last_of_run %0b end_of_frame %0b",
                   $time, pixel_out_i, last_of_run_i, end_of_frame_i);
          fail_count_o++;
        end else begin
          oldest = due_results.pop_front();
          if (pixel_out_i !== oldest.pix) begin
            $display("%0t pixel_out expected %0d actual %0d",
                     $time, $signed(oldest.pix), $signed(pixel_out_i));
            fail_count_o++;
          end
          if (last_of_run_i !== oldest.last) begin
            $display("%0t last_of_run expected %0b actual %0b",
                     $time, oldest.last, last_of_run_i);
            fail_count_o++;
          end
          if (end_of_frame_i !== oldest.eof) begin
            $display("%0t end_of_frame expected %0b actual %0b",
                     $time, oldest.eof, end_of_frame_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) filter_sample(pixel_in_i);
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// testbench top: feeds frames and register writes to the laplacian edge filter

module tb_top;
  import lef_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 200;
  localparam int CALM_ITEMS    = 80;

  logic                     clk     = 1'b0;
  logic                     rst_n   = 1'b0;
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr   = '0;
  logic [APB_DATA_BITS-1:0] pwdata  = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  sample_t                  pixel_in  = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  wide_t                    pixel_out;
  logic                     last_of_run;
  logic                     end_of_frame;

  int fail_count;
  int pending;
  int idle_rate   = 0;
  int stall_left  = 0;
  int quiet       = 0;
  int random_sent = 0;

  always #10 clk = ~clk;

  laplacian_edge_filter uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pixel_in_i     (pixel_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_out_o    (pixel_out),
    .last_of_run_o  (last_of_run),
    .end_of_frame_o (end_of_frame)
  );

  lef_checker lef_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .pixel_in_i     (pixel_in),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_out_i    (pixel_out),
    .last_of_run_i  (last_of_run),
    .end_of_frame_i (end_of_frame),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // receiver stalls in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_rate != 0 && $urandom_range(idle_rate - 1, 0) == 0) begin
      stall_left = $urandom_range(17, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_ADDR_BITS'(4 * idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // unused upper bits carry noise
  task automatic set_frame(input int rows_val, input int cols_val);
    write_reg(REG_FRAME_ROWS, {16'($urandom), 16'(rows_val)});
    write_reg(REG_FRAME_COLS, {21'($urandom), 11'(cols_val)});
  endtask

  task automatic send_pixel(input sample_t value);
    if (idle_rate != 0 && $urandom_range(idle_rate - 1, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and wait until the block has drained
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic sample_t rand_pixel();
    case ($urandom_range(5, 0))
      0:       return sample_t'(16'h8000);
      1:       return sample_t'(16'h7fff);
      2:       return sample_t'($urandom_range(16, 0) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    int rows_val;
    int cols_val;
    int n_pix;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // interior sample at both extremes of the result range
    idle_rate = 4;
    set_frame(3, 3);
    for (int k = 0; k < 9; k++) send_pixel((k == 4) ? sample_t'(16'h7fff) : sample_t'(16'h8000));
    for (int k = 0; k < 9; k++) send_pixel((k == 4) ? sample_t'(16'h8000) : sample_t'(16'h7fff));
    settle();

    // zero rows act as a single row
    set_frame(0, 3);
    send_pixel(sample_t'(0));
    send_pixel(sample_t'(-1));
    send_pixel(sample_t'(16'h7fff));
    settle();

    // oversized column count, then shrink columns under the running counter
    set_frame(0, 2047);
    repeat (30) send_pixel(rand_pixel());
    settle();
    write_reg(REG_FRAME_COLS, APB_DATA_BITS'(5));
    send_pixel(rand_pixel());
    settle();

    // largest row count, then shrink rows under the running counter
    set_frame(65535, 1);
    repeat (25) send_pixel(rand_pixel());
    settle();
    write_reg(REG_FRAME_ROWS, APB_DATA_BITS'(3));
    send_pixel(rand_pixel());
    settle();

    // wide frame, shrunk in the middle of row one
    idle_rate = 0;
    set_frame(3, 200);
    repeat (210) send_pixel(rand_pixel());
    settle();
    idle_rate = 6;
    write_reg(REG_FRAME_COLS, APB_DATA_BITS'(8));
    repeat (9) send_pixel(rand_pixel());
    settle();

    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(2, 0))
        0:       idle_rate = 0;
        1:       idle_rate = 3;
        default: idle_rate = 12;
      endcase
      if (random_sent >= RANDOM_ITEMS - CALM_ITEMS) idle_rate = 0;
      rows_val = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(6, 1);
      case ($urandom_range(9, 0))
        0:       cols_val = 0;
        1, 2:    cols_val = $urandom_range(40, 11);
        default: cols_val = $urandom_range(10, 1);
      endcase
      set_frame(rows_val, cols_val);
      n_pix = ((rows_val == 0) ? 1 : rows_val) * ((cols_val == 0) ? 1 : cols_val);
      repeat ($urandom_range(3, 1)) begin
        for (int k = 0; k < n_pix; k++) send_pixel(rand_pixel());
        random_sent += n_pix;
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
